// ===== rtl/mur_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mur_pkg;

  // Build constants
  localparam int CHANNELS     = 3;
  localparam int SAMPLE_DEPTH = 8;
  localparam int COUNT_MAX    = 60000;

  // Field and state widths
  localparam int CH_W     = 2;
  localparam int LINE_W   = 3;
  localparam int SAMP_W   = 16;
  localparam int TIMER_W  = 20;
  localparam int SLOT_W   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUM_W    = SAMP_W + CNT_W;
  localparam int SPEED_W  = 17;
  localparam int PROD_W   = SPEED_W + SAMP_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_W  = 3'd5;

  // Average divider: 20-bit dividend, 10-bit divisor
  localparam int DIV_W     = 20;
  localparam int DEN_W     = 10;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // cm = speed * avg / (20000 * 256) = ((speed * avg) >> 13) / 625
  // The divide by 625 is a multiply by ceil(2^30 / 625) and a shift by 30,
  // exact for any 20-bit operand.
  localparam int CM_SHIFT    = 13;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] CM_RECIP = 21'd1717987;
  localparam int CM_Q_W      = DIV_W + RECIP_W - RECIP_SHIFT;

  // Measurement phases
  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_MEASURE = 2'd1,
    PH_DONE    = 2'd2,
    PH_NEXT    = 2'd3
  } mur_phase_t;

  // Controller to datapath
  typedef struct packed {
    logic tick;       // ordinary tick: update state, load result
    logic sum_clear;  // start of a distance request
    logic sum_step;   // add one stored sample
    logic avg_start;  // divide sum by count
    logic mul;        // register speed * average
    logic cm_start;   // register the product scaled to centimetres
    logic finish;     // load distance result, advance phase
  } mur_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done_phase;
    logic sum_done;
    logic div_busy;
    logic out_full;
  } mur_st_t;

endpackage

`default_nettype wire

// ===== rtl/mur_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mur_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [mur_pkg::DIV_W-1:0]     dividend,
  input  wire [mur_pkg::DEN_W-1:0]     divisor,
  output logic [mur_pkg::DIV_W-1:0]    quotient,
  output logic                         busy
);
  import mur_pkg::*;

  logic [DIV_W-1:0]     quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = (trial >= {1'b0, den_r});
    diff    = trial - {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != DIV_CNT_W'(1));
    end
  end

  // Payload: quotient bits shift in from the right
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;

endmodule

`default_nettype wire

// ===== rtl/mur_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mur_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  mur_pkg::mur_cmd_t                cmd,
  output mur_pkg::mur_st_t                 st,
  input  wire                              cfg_we,
  input  wire [mur_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [mur_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire [mur_pkg::LINE_W-1:0]        in_echo_levels,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [mur_pkg::LINE_W-1:0]       out_trigger_lines,
  output logic                             out_result_valid,
  output logic [mur_pkg::CH_W-1:0]         out_result_channel,
  output logic [mur_pkg::SAMP_W-1:0]       out_distance_cm,
  output logic [mur_pkg::LINE_W-1:0]       out_obstacle_mask,
  output logic                             out_timed_out
);
  import mur_pkg::*;

  // Configuration registers
  logic [7:0]         obst_r [CHANNELS];
  logic [SPEED_W-1:0] speed_r;
  logic [TIMER_W-1:0] timeout_r;
  logic [7:0]         trig_w_r;

  // Measurement state
  logic [CH_W-1:0]    chan_r, chan_nxt;
  mur_phase_t         phase_r, phase_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [SAMP_W-1:0]  ecnt_r, ecnt_nxt;
  logic               seen_r, seen_nxt;
  logic [SAMP_W-1:0]  samp_r  [CHANNELS][SAMPLE_DEPTH];
  logic [CNT_W-1:0]   count_r [CHANNELS];
  logic [SLOT_W-1:0]  slot_r  [CHANNELS];
  logic [LINE_W-1:0]  obits_r, obits_nxt;

  // Distance arithmetic
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   idx_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DIV_W+RECIP_W-1:0] scale_w;
  logic [CM_Q_W-1:0]  cm_r;
  logic [DIV_W-1:0]   div_quo;
  logic               div_busy;
  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [SAMP_W-1:0]  avg_w;
  logic [SAMP_W-1:0]  dist_w;

  // Output register
  logic               out_valid_r;
  logic [LINE_W-1:0]  trig_out_r;
  logic               res_valid_r;
  logic [CH_W-1:0]    res_ch_r;
  logic [SAMP_W-1:0]  dist_r;
  logic [LINE_W-1:0]  mask_r;
  logic               tout_r;

  // Tick decode
  logic               echo_bit;
  logic [7:0]         tw_eff;
  logic [TIMER_W-1:0] timer_inc;
  logic [TIMER_W:0]   elapsed;
  logic               store_en;
  logic               clear_en;
  logic               go_next;
  logic               ended;
  logic [LINE_W-1:0]  trig_w;
  logic               tout_w;
  logic [CNT_W-1:0]   n_cur;
  logic [SLOT_W-1:0]  slot_cur;

  assign n_cur    = count_r[chan_r];
  assign slot_cur = slot_r[chan_r];
  assign echo_bit = in_echo_levels[chan_r];
  assign tw_eff   = (trig_w_r == 8'd0) ? 8'd1 : trig_w_r;

  // Next measurement state for one ordinary tick
  always_comb begin
    chan_nxt  = chan_r;
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    ecnt_nxt  = ecnt_r;
    seen_nxt  = seen_r;
    store_en  = 1'b0;
    clear_en  = 1'b0;
    go_next   = 1'b0;
    ended     = 1'b0;
    trig_w    = '0;
    tout_w    = 1'b0;
    timer_inc = timer_r + 1'b1;
    elapsed   = {1'b0, timer_r} + 1'b1;
    case (phase_r)
      PH_TRIGGER: begin
        trig_w    = LINE_W'(1) << chan_r;
        timer_nxt = timer_inc;
        if (timer_inc >= {{(TIMER_W-8){1'b0}}, tw_eff}) begin
          phase_nxt = PH_MEASURE;
          ecnt_nxt  = '0;
          seen_nxt  = 1'b0;
        end
      end
      PH_MEASURE: begin
        timer_nxt = elapsed[TIMER_W] ? {TIMER_W{1'b1}} : elapsed[TIMER_W-1:0];
        if (echo_bit) begin
          seen_nxt = 1'b1;
          if (ecnt_r < SAMP_W'(COUNT_MAX)) ecnt_nxt = ecnt_r + 1'b1;
        end else if (seen_r) begin
          store_en  = 1'b1;
          phase_nxt = PH_DONE;
          ended     = 1'b1;
        end
        // echo end wins over timeout
        if (!ended && (elapsed > {1'b0, timeout_r})) begin
          clear_en = 1'b1;
          tout_w   = 1'b1;
          go_next  = 1'b1;
        end
      end
      PH_NEXT: begin
        go_next = 1'b1;
      end
      default: begin
        phase_nxt = PH_TRIGGER;
        timer_nxt = '0;
        ecnt_nxt  = '0;
        seen_nxt  = 1'b0;
      end
    endcase
    if (go_next) begin
      chan_nxt  = (chan_r == CH_W'(CHANNELS - 1)) ? '0 : chan_r + 1'b1;
      phase_nxt = PH_TRIGGER;
      timer_nxt = '0;
      ecnt_nxt  = '0;
      seen_nxt  = 1'b0;
    end
  end

  // Average, distance and obstacle bit; the scaled quotient stays below 2^11,
  // so the distance never reaches saturation
  always_comb begin
    avg_w  = (n_cur == '0) ? '0 : div_quo[SAMP_W-1:0];
    dist_w = {{(SAMP_W-CM_Q_W){1'b0}}, cm_r};
    obits_nxt = obits_r;
    obits_nxt[chan_r] = (dist_w < {8'd0, obst_r[chan_r]});
  end

  // Divide by 625 as a reciprocal multiply
  assign scale_w = {{RECIP_W{1'b0}}, prod_r[PROD_W-1:CM_SHIFT]} * {{DIV_W{1'b0}}, CM_RECIP};

  // Divider for the sample average
  assign div_start = cmd.avg_start;
  assign div_num   = DIV_W'(sum_r);
  assign div_den   = DEN_W'(n_cur);

  mur_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_quo),
    .busy     (div_busy)
  );

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) obst_r[c] <= 8'd30;
      speed_r   <= SPEED_W'(87040);
      timeout_r <= TIMER_W'(60000);
      trig_w_r  <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBST0:   obst_r[0] <= cfg_data[7:0];
        CFG_OBST1:   if (CHANNELS > 1) obst_r[CHANNELS > 1 ? 1 : 0] <= cfg_data[7:0];
        CFG_OBST2:   if (CHANNELS > 2) obst_r[CHANNELS > 2 ? 2 : 0] <= cfg_data[7:0];
        CFG_SPEED:   speed_r   <= cfg_data[SPEED_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_data[TIMER_W-1:0];
        CFG_TRIG_W:  trig_w_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Measurement state and sample rings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= '0;
      phase_r <= PH_TRIGGER;
      timer_r <= '0;
      ecnt_r  <= '0;
      seen_r  <= 1'b0;
      obits_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        count_r[c] <= '0;
        slot_r[c]  <= '0;
        for (int s = 0; s < SAMPLE_DEPTH; s++) samp_r[c][s] <= '0;
      end
    end else if (cmd.tick) begin
      chan_r  <= chan_nxt;
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      ecnt_r  <= ecnt_nxt;
      seen_r  <= seen_nxt;
      if (store_en) begin
        samp_r[chan_r][slot_cur] <= ecnt_r;
        slot_r[chan_r] <= (slot_cur == SLOT_W'(SAMPLE_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
        if (n_cur < CNT_W'(SAMPLE_DEPTH)) count_r[chan_r] <= n_cur + 1'b1;
      end
      if (clear_en) begin
        for (int s = 0; s < SAMPLE_DEPTH; s++) samp_r[chan_r][s] <= '0;
      end
    end else if (cmd.finish) begin
      phase_r <= PH_NEXT;
      obits_r <= obits_nxt;
    end
  end

  // Sum the stored samples one a cycle, then scale the average
  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum_r <= '0;
      idx_r <= '0;
    end else if (cmd.sum_step) begin
      sum_r <= sum_r + SUM_W'(samp_r[chan_r][idx_r[SLOT_W-1:0]]);
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.mul) prod_r <= {{SAMP_W{1'b0}}, speed_r} * {{SPEED_W{1'b0}}, avg_w};
    if (cmd.cm_start) cm_r <= scale_w[DIV_W+RECIP_W-1:RECIP_SHIFT];
  end

  // Output register: load on a finished request, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.tick || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      trig_out_r  <= trig_w;
      res_valid_r <= 1'b0;
      res_ch_r    <= '0;
      dist_r      <= '0;
      mask_r      <= obits_r;
      tout_r      <= tout_w;
    end else if (cmd.finish) begin
      trig_out_r  <= '0;
      res_valid_r <= 1'b1;
      res_ch_r    <= chan_r;
      dist_r      <= dist_w;
      mask_r      <= obits_nxt;
      tout_r      <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_lines  = trig_out_r;
  assign out_result_valid   = res_valid_r;
  assign out_result_channel = res_ch_r;
  assign out_distance_cm    = dist_r;
  assign out_obstacle_mask  = mask_r;
  assign out_timed_out      = tout_r;

  assign st.done_phase = (phase_r == PH_DONE);
  assign st.sum_done   = (idx_r == n_cur);
  assign st.div_busy   = div_busy;
  assign st.out_full   = out_valid_r;

  // A distance result never lands on a result still waiting
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r)
    else $error("distance result loaded over a pending result");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_tick_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |-> (phase_r != PH_DONE))
    else $error("ordinary tick taken in the distance phase");

  a_finish_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (phase_r == PH_NEXT) && out_valid_r && res_valid_r)
    else $error("finish did not report a distance");

endmodule

`default_nettype wire

// ===== rtl/mur_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mur_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                out_stall,
  input  mur_pkg::mur_st_t   st,
  output mur_pkg::mur_cmd_t  cmd
);
  import mur_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_AVG,
    S_MUL,
    S_CM
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Take a request when idle and the output register is free or emptying
  assign in_stall = (state_r != S_IDLE) || (st.out_full && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (st.done_phase) begin
            cmd.sum_clear = 1'b1;
            state_nxt     = S_SUM;
          end else begin
            cmd.tick = 1'b1;
          end
        end
      end
      S_SUM: begin
        if (st.sum_done) begin
          cmd.avg_start = 1'b1;
          state_nxt     = S_AVG;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      S_AVG: begin
        if (!st.div_busy) begin
          cmd.mul   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.cm_start = 1'b1;
        state_nxt    = S_CM;
      end
      S_CM: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // A distance request always begins by clearing the sum
  a_req_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && accept && st.done_phase) |=> (state_r == S_SUM))
    else $error("distance request did not start the sum");

  a_cm_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cm_start |-> $past(cmd.mul))
    else $error("centimetre scale started without a product");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !accept)
    else $error("request taken during a distance computation");

endmodule

`default_nettype wire

// ===== rtl/multichannel_ultrasonic_ranger_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordinary ticks (trigger, measure, channel advance): result registered in the cycle
//   after the request is taken; one request per cycle while the output drains.
// Distance tick: the stored samples (up to 8) are summed one a cycle, a radix-2
//   divider forms the average, then two multiply stages scale it to centimetres.
// Reset (rst_n low, synchronous) clears the channel state, sample rings, counts and
//   obstacle bits, and loads every configuration register with its default.

module multichannel_ultrasonic_ranger_top (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [mur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [mur_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [mur_pkg::LINE_W-1:0]       in_echo_levels,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [mur_pkg::LINE_W-1:0]      out_trigger_lines,
  output logic                            out_result_valid,
  output logic [mur_pkg::CH_W-1:0]        out_result_channel,
  output logic [mur_pkg::SAMP_W-1:0]      out_distance_cm,
  output logic [mur_pkg::LINE_W-1:0]      out_obstacle_mask,
  output logic                            out_timed_out
);
  import mur_pkg::*;

  mur_cmd_t cmd;
  mur_st_t  st;

  mur_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  mur_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_echo_levels     (in_echo_levels),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trigger_lines  (out_trigger_lines),
    .out_result_valid   (out_result_valid),
    .out_result_channel (out_result_channel),
    .out_distance_cm    (out_distance_cm),
    .out_obstacle_mask  (out_obstacle_mask),
    .out_timed_out      (out_timed_out)
  );

endmodule

`default_nettype wire
